// File: sv/texel_to_rgba8_converter_unit_macros.svh
// assertion helpers shared by the converter rtl
`ifndef TEXEL_TO_RGBA8_CONVERTER_UNIT_MACROS_SVH
`define TEXEL_TO_RGBA8_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, checked only out of reset
`define TTR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("converter assertion failed");

// next-cycle implication, checked only out of reset
`define TTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("converter assertion failed");

`endif

// File: sv/ttr_pkg.sv
`default_nettype none

package ttr_pkg;

    localparam int unsigned PaletteEntries = 256;
    localparam int unsigned PalIdxW  = (PaletteEntries > 1) ? $clog2(PaletteEntries) : 1;
    localparam int unsigned SlotW    = 8;
    localparam int unsigned RgbW     = 24;
    localparam int unsigned TexelW   = 32;
    localparam int unsigned ApbAddrW = 4;
    localparam int unsigned ApbDataW = 32;

    // source formats
    localparam logic [1:0] FmtPalette  = 2'd0;
    localparam logic [1:0] FmtPacked16 = 2'd1;
    localparam logic [1:0] FmtRgb24    = 2'd2;
    localparam logic [1:0] FmtGbpr32   = 2'd3;

    // 16-bit layouts
    localparam logic [1:0] Layout565  = 2'd0;
    localparam logic [1:0] Layout1555 = 2'd1;
    localparam logic [1:0] Layout4444 = 2'd2;
    localparam logic [1:0] Layout8332 = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [1:0] RegSourceFormat = 2'd0;
    localparam logic [1:0] RegPackedLayout = 2'd1;
    localparam logic [1:0] RegColorKey     = 2'd2;

    localparam logic [31:0] KeyDisabled       = 32'hFFFF_FFFF;
    localparam logic [1:0]  SourceFormatReset = FmtRgb24;
    localparam logic [1:0]  PackedLayoutReset = Layout565;
    localparam logic [7:0]  AlphaOpaque       = 8'hFF;
    localparam logic [7:0]  AlphaKeyed        = 8'h00;

    typedef struct packed {
        logic [1:0]  source_format;
        logic [1:0]  packed_layout;
        logic [31:0] color_key;
    } cfg_t;

    // red in the low byte so the struct packs straight onto tdata
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    // floor(255*f/fmax) tables for field widths whose max does not divide 255
    localparam int unsigned Max3 = 7;
    localparam int unsigned Max5 = 31;
    localparam int unsigned Max6 = 63;

    typedef logic [7:0] exp3_tab_t [8];
    typedef logic [7:0] exp5_tab_t [32];
    typedef logic [7:0] exp6_tab_t [64];

    function automatic exp3_tab_t build_exp3();
        exp3_tab_t tab;
        for (int i = 0; i < 8; i++) begin
            tab[i] = 8'((255 * i) / Max3);
        end
        return tab;
    endfunction

    function automatic exp5_tab_t build_exp5();
        exp5_tab_t tab;
        for (int i = 0; i < 32; i++) begin
            tab[i] = 8'((255 * i) / Max5);
        end
        return tab;
    endfunction

    function automatic exp6_tab_t build_exp6();
        exp6_tab_t tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = 8'((255 * i) / Max6);
        end
        return tab;
    endfunction

    localparam exp3_tab_t Expand3 = build_exp3();
    localparam exp5_tab_t Expand5 = build_exp5();
    localparam exp6_tab_t Expand6 = build_exp6();

endpackage

`default_nettype wire

// File: sv/ttr_apb_regs.sv
`default_nettype none

module ttr_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttr_pkg::ApbAddrW-1:0]    paddr,
    input  logic [ttr_pkg::ApbDataW-1:0]    pwdata,
    output logic [ttr_pkg::ApbDataW-1:0]    prdata,
    output logic                            pready,
    output ttr_pkg::cfg_t                   cfg
);

    logic [1:0]  source_format_reg;
    logic [1:0]  packed_layout_reg;
    logic [31:0] color_key_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ttr_pkg::ApbAddrW-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= ttr_pkg::SourceFormatReset;
            packed_layout_reg <= ttr_pkg::PackedLayoutReset;
            color_key_reg     <= ttr_pkg::KeyDisabled;
        end else if (wr_en) begin
            case (reg_idx)
                ttr_pkg::RegSourceFormat: source_format_reg <= pwdata[1:0];
                ttr_pkg::RegPackedLayout: packed_layout_reg <= pwdata[1:0];
                ttr_pkg::RegColorKey:     color_key_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ttr_pkg::RegSourceFormat: prdata = {30'd0, source_format_reg};
            ttr_pkg::RegPackedLayout: prdata = {30'd0, packed_layout_reg};
            ttr_pkg::RegColorKey:     prdata = color_key_reg;
            default:                  prdata = '0;
        endcase
    end

    assign cfg.source_format = source_format_reg;
    assign cfg.packed_layout = packed_layout_reg;
    assign cfg.color_key     = color_key_reg;

endmodule

`default_nettype wire

// File: sv/ttr_palette_ram.sv
`default_nettype none

module ttr_palette_ram (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [ttr_pkg::PalIdxW-1:0]     wr_addr,
    input  logic [ttr_pkg::RgbW-1:0]        wr_data,
    input  logic                            rd_en,
    input  logic [ttr_pkg::PalIdxW-1:0]     rd_addr,
    output logic [ttr_pkg::RgbW-1:0]        rd_data
);

    logic [ttr_pkg::RgbW-1:0] mem_reg [ttr_pkg::PaletteEntries];
    logic [ttr_pkg::RgbW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/ttr_convert.sv
`default_nettype none

module ttr_convert (
    input  ttr_pkg::cfg_t                   cfg,
    input  logic [ttr_pkg::TexelW-1:0]      texel_bytes,
    input  logic [ttr_pkg::RgbW-1:0]        palette_rgb,
    output ttr_pkg::rgba_t                  rgba
);

    logic [15:0] w;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        key_hit;

    assign w = texel_bytes[15:0];

    always_comb begin
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        a = ttr_pkg::AlphaOpaque;
        case (cfg.source_format)
            ttr_pkg::FmtPalette: begin
                r = palette_rgb[23:16];
                g = palette_rgb[15:8];
                b = palette_rgb[7:0];
            end
            ttr_pkg::FmtPacked16: begin
                case (cfg.packed_layout)
                    ttr_pkg::Layout565: begin
                        r = ttr_pkg::Expand5[w[15:11]];
                        g = ttr_pkg::Expand6[w[10:5]];
                        b = ttr_pkg::Expand5[w[4:0]];
                    end
                    ttr_pkg::Layout1555: begin
                        r = ttr_pkg::Expand5[w[14:10]];
                        g = ttr_pkg::Expand5[w[9:5]];
                        b = ttr_pkg::Expand5[w[4:0]];
                        a = {8{w[15]}};
                    end
                    ttr_pkg::Layout4444: begin
                        // 255/15 = 17, so a nibble just repeats
                        r = {w[11:8], w[11:8]};
                        g = {w[7:4], w[7:4]};
                        b = {w[3:0], w[3:0]};
                        a = {w[15:12], w[15:12]};
                    end
                    default: begin
                        r = ttr_pkg::Expand3[w[7:5]];
                        g = ttr_pkg::Expand3[w[4:2]];
                        // 255/3 = 85, a repeated bit pair
                        b = {4{w[1:0]}};
                        a = w[15:8];
                    end
                endcase
            end
            ttr_pkg::FmtRgb24: begin
                r = texel_bytes[7:0];
                g = texel_bytes[15:8];
                b = texel_bytes[23:16];
            end
            default: begin
                g = texel_bytes[7:0];
                b = texel_bytes[15:8];
                r = texel_bytes[31:24];
            end
        endcase
    end

    assign key_hit = (cfg.color_key != ttr_pkg::KeyDisabled) &&
                     ({r, g, b} == cfg.color_key[23:0]);

    assign rgba.red   = r;
    assign rgba.green = g;
    assign rgba.blue  = b;
    assign rgba.alpha = key_hit ? ttr_pkg::AlphaKeyed : a;

endmodule

`default_nettype wire

// File: sv/texel_to_rgba8_converter_unit.sv
// Texel to RGBA8 converter: takes one texel (or one palette write) per clock on the s_ stream
// and returns one 8-bit RGBA item per converted texel on the m_ stream. The edge that accepts
// a texel loads it into stage 1 together with the synchronous read of the 256-entry palette
// memory; when stage 1 advances, the format expansion and color-key compare feed the output
// register, whose load raises m_tvalid; both stages move every cycle, so throughput is
// one texel per clock unless m_tready is held low. A palette write (tuser = 1) updates the
// memory at the cycle it is accepted and gives no output item; a texel that follows it in the
// next cycle already sees the new entry. The palette has no reset and no clearing pass: an
// index must be written before it is looked up. Registers on the APB port (source format at
// 0x0, 16-bit layout at 0x4, color key at 0x8) should only be written while the stream is idle.
`default_nettype none

module texel_to_rgba8_converter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // texel_bytes[31:0], palette_slot[39:32], palette_rgb[63:40]
    input  logic [63:0]                     s_tdata,
    // command[0]: 0 convert texel, 1 write palette entry
    input  logic                            s_tuser,
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    output logic [31:0]                     m_tdata,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttr_pkg::ApbAddrW-1:0]    paddr,
    input  logic [ttr_pkg::ApbDataW-1:0]    pwdata,
    output logic [ttr_pkg::ApbDataW-1:0]    prdata,
    output logic                            pready
);

    `include "texel_to_rgba8_converter_unit_macros.svh"

    ttr_pkg::cfg_t                  cfg;
    ttr_pkg::rgba_t                 rgba_next;
    ttr_pkg::rgba_t                 m_data_reg;

    logic [ttr_pkg::TexelW-1:0]     in_texel;
    logic [ttr_pkg::SlotW-1:0]      in_slot;
    logic [ttr_pkg::RgbW-1:0]       in_rgb;
    logic                           in_accept;
    logic                           acc_convert;
    logic                           acc_write;
    logic                           slot_in_range;
    logic                           idx_in_range;

    logic                           v1_reg;
    logic                           v1_next;
    logic [ttr_pkg::TexelW-1:0]     texel_reg;
    logic                           pal_oob_reg;
    logic [ttr_pkg::RgbW-1:0]       pal_rd_data;
    logic [ttr_pkg::RgbW-1:0]       pal_color;

    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic                           out_ready;
    logic                           advance;

    assign in_texel = s_tdata[31:0];
    assign in_slot  = s_tdata[39:32];
    assign in_rgb   = s_tdata[63:40];

    assign out_ready   = !m_tvalid_reg || m_tready;
    assign advance     = v1_reg && out_ready;
    assign s_tready    = !v1_reg || out_ready;
    assign in_accept   = s_tvalid && s_tready;
    assign acc_convert = in_accept && !s_tuser;
    assign acc_write   = in_accept && s_tuser;

    assign slot_in_range = {1'b0, in_slot} < 9'(ttr_pkg::PaletteEntries);
    assign idx_in_range  = {1'b0, in_texel[7:0]} < 9'(ttr_pkg::PaletteEntries);

    ttr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttr_palette_ram u_palette (
        .aclk    (aclk),
        .wr_en   (acc_write && slot_in_range),
        .wr_addr (in_slot[ttr_pkg::PalIdxW-1:0]),
        .wr_data (in_rgb),
        .rd_en   (acc_convert),
        .rd_addr (in_texel[ttr_pkg::PalIdxW-1:0]),
        .rd_data (pal_rd_data)
    );

    // stage 1: texel alongside the palette read
    assign v1_next = acc_convert ? 1'b1 : (advance ? 1'b0 : v1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_convert) begin
            texel_reg   <= in_texel;
            pal_oob_reg <= !idx_in_range;
        end
    end

    assign pal_color = pal_oob_reg ? '0 : pal_rd_data;

    ttr_convert u_convert (
        .cfg         (cfg),
        .texel_bytes (texel_reg),
        .palette_rgb (pal_color),
        .rgba        (rgba_next)
    );

    // stage 2: output register
    assign m_tvalid_next = advance ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= rgba_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    `TTR_ASSERT_NEXT(a_convert_enters_stage1, acc_convert, v1_reg)
    `TTR_ASSERT_NEXT(a_write_leaves_stage1_empty, acc_write && !v1_reg, !v1_reg)
    `TTR_ASSERT_NEXT(a_stage1_moves_to_output, advance, m_tvalid_reg)
    `TTR_ASSERT_IMPLIES(a_full_pipe_blocks_input, v1_reg && m_tvalid_reg && !m_tready, !s_tready)

endmodule

`default_nettype wire

// File: bench/texel_to_rgba8_converter_unit_tb.sv
`timescale 1ns / 1ps

module texel_to_rgba8_converter_unit_tb;
    import ttr_pkg::*;

    localparam bit CmdConvert      = 1'b0;
    localparam bit CmdPaletteWrite = 1'b1;

    localparam int Phases        = 12;
    localparam int ItemsPerPhase = 135;
    localparam int DrainCycles   = 6;
    localparam int HoldCycles    = 200;
    localparam int CycleLimit    = 300000;

    class texel_scoreboard;
        cfg_t        cfg;
        logic [23:0] palette [PaletteEntries];
        bit          loaded [PaletteEntries];
        rgba_t       expected_q [$];
        int          errors;

        function new();
            cfg.source_format = SourceFormatReset;
            cfg.packed_layout = PackedLayoutReset;
            cfg.color_key     = KeyDisabled;
            errors = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                RegSourceFormat: cfg.source_format = val[1:0];
                RegPackedLayout: cfg.packed_layout = val[1:0];
                RegColorKey:     cfg.color_key     = val;
                default: ;
            endcase
        endfunction

        // floor(255*f/fmax) for the field at shift
        function logic [7:0] widen(logic [15:0] word, int shift, int fmax);
            int unsigned field;
            field = (word >> shift) & fmax;
            return 8'((255 * field) / fmax);
        endfunction

        // color of a texel before keying
        function rgba_t decode(logic [31:0] bytes);
            rgba_t       px;
            logic [23:0] c;
            px.alpha = AlphaOpaque;
            case (cfg.source_format)
                FmtPalette: begin
                    c = (bytes[7:0] < PaletteEntries) ? palette[bytes[7:0]] : 24'h0;
                    {px.red, px.green, px.blue} = c;
                end
                FmtPacked16: begin
                    case (cfg.packed_layout)
                        Layout565: begin
                            px.red   = widen(bytes[15:0], 11, 31);
                            px.green = widen(bytes[15:0], 5, 63);
                            px.blue  = widen(bytes[15:0], 0, 31);
                        end
                        Layout1555: begin
                            px.red   = widen(bytes[15:0], 10, 31);
                            px.green = widen(bytes[15:0], 5, 31);
                            px.blue  = widen(bytes[15:0], 0, 31);
                            px.alpha = widen(bytes[15:0], 15, 1);
                        end
                        Layout4444: begin
                            px.red   = widen(bytes[15:0], 8, 15);
                            px.green = widen(bytes[15:0], 4, 15);
                            px.blue  = widen(bytes[15:0], 0, 15);
                            px.alpha = widen(bytes[15:0], 12, 15);
                        end
                        default: begin
                            px.red   = widen(bytes[15:0], 5, 7);
                            px.green = widen(bytes[15:0], 2, 7);
                            px.blue  = widen(bytes[15:0], 0, 3);
                            px.alpha = widen(bytes[15:0], 8, 255);
                        end
                    endcase
                end
                FmtRgb24: begin
                    px.red   = bytes[7:0];
                    px.green = bytes[15:8];
                    px.blue  = bytes[23:16];
                end
                default: begin
                    px.green = bytes[7:0];
                    px.blue  = bytes[15:8];
                    px.red   = bytes[31:24];
                end
            endcase
            return px;
        endfunction

        function void note_input(bit cmd, logic [31:0] bytes, logic [7:0] slot,
                                 logic [23:0] rgb);
            rgba_t px;
            if (cmd == CmdPaletteWrite) begin
                if (slot < PaletteEntries) begin
                    palette[slot] = rgb;
                    loaded[slot]  = 1'b1;
                end
            end else begin
                px = decode(bytes);
                if (cfg.color_key != KeyDisabled &&
                    {px.red, px.green, px.blue} == cfg.color_key[23:0])
                    px.alpha = AlphaKeyed;
                expected_q.push_back(px);
            end
        endfunction

        function void check_result(logic [31:0] data);
            string       names [4];
            logic [31:0] want;
            names = '{"red", "green", "blue", "alpha"};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected item %08h", $time, data);
                errors++;
            end else begin
                want = expected_q.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (data[8*k +: 8] !== want[8*k +: 8]) begin
                        $display("%0t: %s mismatch expected %02h got %02h", $time, names[k],
                                 want[8*k +: 8], data[8*k +: 8]);
                        errors++;
                    end
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [63:0]         s_tdata;   // texel_bytes[31:0], palette_slot[39:32], palette_rgb[63:40]
    logic                s_tuser;   // command[0]
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    texel_scoreboard sb = new();

    bit sender_gaps    = 1'b0;
    bit receive_stalls = 1'b1;
    bit hold_request   = 1'b0;
    int cycle_count    = 0;

    texel_to_rgba8_converter_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // handshakes are decided by values stable at the falling edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        int stall;
        bit got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = receive_stalls ? $urandom_range(0, 5) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                @(posedge aclk);
            end while (!got);
        end
    end

    task automatic send_item(input bit cmd, input logic [31:0] bytes, input logic [7:0] slot,
                             input logic [23:0] rgb);
        int gap;
        bit taken;
        gap = sender_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rgb, slot, bytes};
        do begin
            @(negedge aclk);
            taken = s_tready;
            if (taken)
                sb.note_input(cmd, bytes, slot, rgb);
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic send_texel(input logic [31:0] bytes);
        send_item(CmdConvert, bytes, 8'($urandom()), 24'($urandom()));
    endtask

    task automatic load_palette(input logic [7:0] slot, input logic [23:0] rgb);
        send_item(CmdPaletteWrite, $urandom(), slot, rgb);
    endtask

    // stop offering and wait until every expected item has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        bit rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            rdy = pready;
            @(posedge aclk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    function automatic logic [7:0] pick_loaded();
        int s;
        do s = $urandom_range(0, PaletteEntries - 1); while (!sb.loaded[s]);
        return 8'(s);
    endfunction

    // texel bits that leave the color unchanged
    function automatic logic [31:0] color_free_bits(logic [1:0] fmt, logic [1:0] lay);
        case (fmt)
            FmtPalette:  return 32'hFFFF_FF00;
            FmtPacked16: begin
                case (lay)
                    Layout565:  return 32'hFFFF_0000;
                    Layout1555: return 32'hFFFF_8000;
                    Layout4444: return 32'hFFFF_F000;
                    default:    return 32'hFFFF_FF00;
                endcase
            end
            FmtRgb24:    return 32'hFF00_0000;
            default:     return 32'h00FF_0000;
        endcase
    endfunction

    task automatic random_item(input logic [1:0] fmt, input logic [1:0] lay,
                               input logic [31:0] key_texel, input logic [23:0] key_rgb);
        int          roll;
        int          sel;
        int          write_pct;
        logic [31:0] bytes;
        write_pct = (fmt == FmtPalette) ? 30 : 8;
        roll = $urandom_range(0, 99);
        if (roll < write_pct) begin
            load_palette(8'($urandom_range(0, 255)),
                         ($urandom_range(0, 4) == 0) ? key_rgb : 24'($urandom()));
        end else begin
            bytes = $urandom();
            sel   = $urandom_range(0, 9);
            if (sel < 3)
                bytes = key_texel ^ (bytes & color_free_bits(fmt, lay));
            else if (sel == 3)
                bytes = 32'h0;
            else if (sel == 4)
                bytes = 32'hFFFF_FFFF;
            if (fmt == FmtPalette && sel >= 3)
                bytes[7:0] = pick_loaded();
            send_texel(bytes);
        end
    endtask

    initial begin
        logic [1:0]  phase_fmt [Phases];
        logic [1:0]  phase_lay [Phases];
        int          phase_key [Phases];
        logic [31:0] key_texel;
        logic [31:0] key;
        logic [23:0] key_rgb;
        rgba_t       px;

        // key modes: 0 off, 1 key texel color, 2 same with random top byte, 3 all zero
        phase_fmt = '{FmtRgb24, FmtPalette, FmtPacked16, FmtPacked16, FmtPacked16, FmtPacked16,
                      FmtGbpr32, FmtPalette, FmtPacked16, FmtRgb24, FmtGbpr32, FmtPacked16};
        phase_lay = '{Layout565, Layout565, Layout565, Layout1555, Layout4444, Layout8332,
                      Layout1555, Layout4444, Layout8332, Layout565, Layout565, Layout4444};
        phase_key = '{0, 1, 1, 2, 1, 1, 2, 0, 1, 3, 1, 1};

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CmdConvert;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config is 24-bit rgb with keying off
        send_texel(32'h0000_0000);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'hA5C3_E17F);
        load_palette(8'h00, 24'hFFFFFF);
        load_palette(8'hFF, 24'h000000);
        load_palette(8'h5A, 24'h123456);
        settle();
        write_reg(RegSourceFormat, 32'(FmtPalette));
        send_texel(32'hFFFF_FF00);
        send_texel(32'h0000_00FF);
        send_texel(32'h0000_005A);
        // overwrite then read the same entry back to back
        load_palette(8'h5A, 24'hFEDCBA);
        send_texel(32'h0000_005A);
        settle();
        write_reg(RegSourceFormat, 32'(FmtPacked16));
        send_texel(32'h0000_FFFF);
        send_texel(32'hFFFF_0000);
        settle();
        write_reg(RegPackedLayout, 32'(Layout1555));
        send_texel(32'h0000_8000);
        send_texel(32'h0000_7FFF);
        settle();
        write_reg(RegPackedLayout, 32'(Layout4444));
        send_texel(32'h0000_F0F0);
        send_texel(32'h0000_0F0F);
        settle();
        write_reg(RegPackedLayout, 32'(Layout8332));
        send_texel(32'h0000_FF00);
        send_texel(32'h0000_00FF);
        settle();
        // top byte of the key is ignored unless the whole key is all ones
        write_reg(RegSourceFormat, 32'(FmtGbpr32));
        write_reg(RegColorKey, 32'hFF00_0000);
        send_texel(32'h00AB_0000);
        send_texel(32'hFFFF_FFFF);
        settle();
        write_reg(RegColorKey, 32'h00FF_FFFF);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h01FF_FFFF);

        for (int ph = 0; ph < Phases; ph++) begin
            settle();
            write_reg(RegSourceFormat, 32'(phase_fmt[ph]));
            write_reg(RegPackedLayout, 32'(phase_lay[ph]));
            key_texel = $urandom();
            if (phase_fmt[ph] == FmtPalette)
                key_texel[7:0] = pick_loaded();
            px      = sb.decode(key_texel);
            key_rgb = {px.red, px.green, px.blue};
            case (phase_key[ph])
                0:       key = KeyDisabled;
                1:       key = {8'h00, key_rgb};
                2:       key = {8'($urandom()), key_rgb};
                default: key = 32'h0;
            endcase
            write_reg(RegColorKey, key);
            sender_gaps    = ($urandom_range(0, 3) != 0);
            receive_stalls = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ItemsPerPhase; n++) begin
                // receiver holds off long enough to back up the input
                if (n == 40 && ph % 5 == 2)
                    hold_request = 1'b1;
                if (n == 90 && ph % 4 == 1)
                    settle();
                random_item(phase_fmt[ph], phase_lay[ph], key_texel, key_rgb);
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
